FILE: hw/rtl/bounded_doubly_linked_list_engine_assert.svh
// Assertion macros for the list engine checker.
`ifndef BOUNDED_DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
// Implication that must hold on every clock edge outside reset.
`define BDL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define BDL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hw/rtl/bdll_pkg.sv
//------------------------------------------------------------------------------
// bdll_pkg
// Shared constants, types and codes of the list engine.
//------------------------------------------------------------------------------
`default_nettype none
package bdll_pkg;
  localparam int Capacity   = 64;
  localparam int ValueWidth = 32;
  localparam int IdxW       = $clog2(Capacity);
  localparam int LinkW      = $clog2(Capacity + 1);
  localparam logic [LinkW-1:0] NilLink = LinkW'(Capacity);

  localparam logic [2:0] CmdPushFront = 3'd0;
  localparam logic [2:0] CmdPushBack  = 3'd1;
  localparam logic [2:0] CmdInsertAt  = 3'd2;
  localparam logic [2:0] CmdRemoveAt  = 3'd3;
  localparam logic [2:0] CmdRemoveVal = 3'd4;
  localparam logic [2:0] CmdFindVal   = 3'd5;
  localparam logic [2:0] CmdReadAt    = 3'd6;
  localparam logic [2:0] CmdUnused    = 3'd7;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WALK, S_INS_A, S_INS_B, S_INS_C,
    S_REM_A, S_REM_B, S_REM_C, S_FAIL, S_RESP
  } state_t;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_STEP, OP_INS_A, OP_INS_B, OP_INS_C,
    OP_REM_A, OP_REM_B, OP_REM_C, OP_FAIL, OP_OK
  } op_t;

  typedef struct packed {
    op_t op;
    logic insert;   // command is an insert
    logic by_value; // walk compares values
  } ctl_t;

  typedef struct packed {
    logic full;
    logic invalid;   // unused code or position out of range
    logic walk_done; // walk reached its target
    logic walk_miss; // walk ran off the end
  } sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/bdll_ctrl.sv
//------------------------------------------------------------------------------
// bdll_ctrl
// Command sequencer of the list engine.
//------------------------------------------------------------------------------
`default_nettype none
module bdll_ctrl
  import bdll_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [2:0] cmd,
  input  sts_t            sts,
  output ctl_t            ctl,
  output logic            busy,
  output logic            done
);
  state_t state_r, state_nxt;
  logic [2:0] cmd_r;
  logic ins, byv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= cmd;
    end
  end

  assign ins = (cmd_r == CmdPushFront) || (cmd_r == CmdPushBack) ||
               (cmd_r == CmdInsertAt);
  assign byv = (cmd_r == CmdRemoveVal) || (cmd_r == CmdFindVal);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_DECODE;
      S_DECODE: begin
        if (sts.invalid || (ins && sts.full)) state_nxt = S_FAIL;
        else state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_miss) state_nxt = ins ? S_INS_A : S_FAIL;
        else if (sts.walk_done) begin
          if (ins) state_nxt = S_INS_A;
          else if (cmd_r == CmdRemoveAt || cmd_r == CmdRemoveVal) state_nxt = S_REM_A;
          else state_nxt = S_RESP;
        end
      end
      S_INS_A: state_nxt = S_INS_B;
      S_INS_B: state_nxt = S_INS_C;
      S_INS_C: state_nxt = S_RESP;
      S_REM_A: state_nxt = S_REM_B;
      S_REM_B: state_nxt = S_REM_C;
      S_REM_C: state_nxt = S_RESP;
      S_FAIL:  state_nxt = S_IDLE;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op = OP_NONE;
    ctl.insert = ins;
    ctl.by_value = byv;
    busy = (state_r != S_IDLE);
    done = 1'b0;
    unique case (state_r)
      S_IDLE:   ctl.op = OP_LOAD;
      S_DECODE: ctl.op = OP_NONE;
      S_WALK:   ctl.op = OP_STEP;
      S_INS_A:  ctl.op = OP_INS_A;
      S_INS_B:  ctl.op = OP_INS_B;
      S_INS_C:  ctl.op = OP_INS_C;
      S_REM_A:  ctl.op = OP_REM_A;
      S_REM_B:  ctl.op = OP_REM_B;
      S_REM_C:  ctl.op = OP_REM_C;
      S_FAIL: begin
        ctl.op = OP_FAIL;
        done = 1'b1;
      end
      S_RESP: begin
        ctl.op = OP_OK;
        done = 1'b1;
      end
      default: ctl.op = OP_NONE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/bdll_dp.sv
//------------------------------------------------------------------------------
// bdll_dp
// Node pool, links, list pointers and response registers.
//------------------------------------------------------------------------------
`default_nettype none
module bdll_dp
  import bdll_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire logic [2:0]            in_cmd,
  input  wire logic [7:0]            in_pos,
  input  wire logic [ValueWidth-1:0] in_val,
  input  ctl_t                       ctl,
  output sts_t                       sts,
  output logic [1:0]                 status,
  output logic [6:0]                 found_position,
  output logic [ValueWidth-1:0]      read_value,
  output logic [6:0]                 length
);
  // Free list is held as a fill count over the never-used region plus a
  // recycled chain, so the next links need no clearing pass.
  logic [ValueWidth-1:0] vals_m [Capacity];
  logic [LinkW-1:0]      next_m [Capacity];
  logic [LinkW-1:0]      prev_m [Capacity];

  logic [LinkW-1:0] head_r, tail_r, free_r, fill_r, cnt_r;
  logic [2:0]       cmd_r;
  logic [7:0]       pos_r;
  logic [ValueWidth-1:0] val_r;
  logic [LinkW-1:0] cur_r, cur_nxt, step_r, node_r, pred_r, succ_r;
  logic [ValueWidth-1:0] vals_rd_r;
  logic [LinkW-1:0] next_rd_r, prev_rd_r, free_link_r;
  logic [1:0]       st_r;
  logic [6:0]       rpos_r;
  logic [ValueWidth-1:0] rval_r;
  logic [8:0]       target;
  logic [LinkW-1:0] new_n;
  logic             hit;

  // Target position for an insert, clamped to the end.
  always_comb begin
    unique case (cmd_r)
      CmdPushFront: target = '0;
      CmdPushBack:  target = 9'(cnt_r);
      default:      target = ({1'b0, pos_r} > 9'(cnt_r)) ? 9'(cnt_r) : {1'b0, pos_r};
    endcase
  end

  assign new_n = (free_r != NilLink) ? free_r : fill_r;
  assign hit = (cur_r != NilLink) && (vals_rd_r == val_r);

  always_comb begin
    sts.full    = (cnt_r == LinkW'(Capacity));
    sts.invalid = (cmd_r == CmdUnused) ||
                  ((cmd_r == CmdRemoveAt || cmd_r == CmdReadAt) &&
                   ({1'b0, pos_r} >= 9'(cnt_r)));
    sts.walk_miss = ctl.by_value ? (cur_r == NilLink) :
                    (ctl.insert && cur_r == NilLink);
    sts.walk_done = ctl.by_value ? hit : (9'(step_r) == (ctl.insert ? target : {1'b0, pos_r}));
  end

  // Walk pointer: start at the head, advance one link per step.
  always_comb begin
    cur_nxt = cur_r;
    if (ctl.op == OP_NONE) begin
      cur_nxt = head_r;
    end else if (ctl.op == OP_STEP && !sts.walk_done && !sts.walk_miss) begin
      cur_nxt = next_rd_r;
    end
  end

  // Registered pool reads, addressed one step ahead so the data of the
  // current node is ready together with the walk pointer.
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    vals_rd_r   <= vals_m[cur_nxt[IdxW-1:0]];
    next_rd_r   <= next_m[cur_nxt[IdxW-1:0]];
    prev_rd_r   <= prev_m[cur_nxt[IdxW-1:0]];
    free_link_r <= next_m[free_r[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= in_cmd;
      pos_r <= in_pos;
      val_r <= in_val;
    end
  end

  // Walk, relink and response.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NilLink;
      tail_r <= NilLink;
      free_r <= NilLink;
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      unique case (ctl.op)
        OP_INS_A: begin
          if (free_r != NilLink) free_r <= free_link_r;
          else fill_r <= fill_r + 1'b1;
        end
        OP_INS_C: begin
          if (pred_r == NilLink) head_r <= node_r;
          if (succ_r == NilLink) tail_r <= node_r;
          cnt_r <= cnt_r + 1'b1;
        end
        OP_REM_C: begin
          if (pred_r == NilLink) head_r <= succ_r;
          if (succ_r == NilLink) tail_r <= pred_r;
          free_r <= node_r;
          cnt_r <= cnt_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        step_r <= '0;
      end
      OP_NONE: begin
        step_r <= '0;
      end
      OP_STEP: begin
        if (!sts.walk_done && !sts.walk_miss) begin
          step_r <= step_r + 1'b1;
        end
      end
      OP_INS_A: begin
        node_r <= new_n;
        succ_r <= cur_r;
        pred_r <= (cur_r == NilLink) ? tail_r : prev_rd_r;
      end
      OP_INS_B: begin
        vals_m[node_r[IdxW-1:0]] <= val_r;
        next_m[node_r[IdxW-1:0]] <= succ_r;
        prev_m[node_r[IdxW-1:0]] <= pred_r;
      end
      OP_INS_C: begin
        if (pred_r != NilLink) next_m[pred_r[IdxW-1:0]] <= node_r;
        if (succ_r != NilLink) prev_m[succ_r[IdxW-1:0]] <= node_r;
        st_r   <= StDone;
        rpos_r <= target[6:0];
        rval_r <= val_r;
      end
      OP_REM_A: begin
        node_r <= cur_r;
        pred_r <= prev_rd_r;
        succ_r <= next_rd_r;
        rval_r <= vals_rd_r;
        rpos_r <= step_r[6:0];
        st_r   <= StDone;
      end
      OP_REM_B: begin
        if (pred_r != NilLink) next_m[pred_r[IdxW-1:0]] <= succ_r;
        if (succ_r != NilLink) prev_m[succ_r[IdxW-1:0]] <= pred_r;
      end
      OP_REM_C: begin
        next_m[node_r[IdxW-1:0]] <= free_r;
        prev_m[node_r[IdxW-1:0]] <= NilLink;
      end
      OP_FAIL: ;
      OP_OK: ;
      default: ;
    endcase
    // Capture a read or find result as the walk completes.
    if (ctl.op == OP_STEP && sts.walk_done && !ctl.insert) begin
      rval_r <= vals_rd_r;
      rpos_r <= step_r[6:0];
      st_r   <= StDone;
    end
  end

  always_comb begin
    status = StNotFound;
    found_position = '0;
    read_value = '0;
    if (ctl.op == OP_OK) begin
      status = st_r;
      found_position = rpos_r;
      read_value = rval_r;
    end else if (ctl.op == OP_FAIL && ctl.insert && sts.full && cmd_r != CmdUnused) begin
      status = StFull;
    end
    length = 7'(cnt_r);
  end
endmodule
`default_nettype wire

FILE: hw/rtl/bounded_doubly_linked_list_engine.sv
//------------------------------------------------------------------------------
// bounded_doubly_linked_list_engine
// Ordered list of values in a 64-node pool with forward and back links.
//------------------------------------------------------------------------------
// Usage:
//   Raise start with in_command, in_position and in_value while busy is low;
//   the item is taken on that edge and busy rises on the next cycle.
//   Exactly one result follows, shown for one cycle with out_valid high:
//   out_status, out_found_position, out_read_value and out_length.
// Sequence:
//   Rejected commands (unused code, position past the end, full pool) go from
//   decode straight to the failure result. Commands walk the list one link per
//   cycle from the head: a read or find answers where it stops, an insert or
//   remove at its position then relinks the nodes before it answers, and a
//   value that is absent fails at the end of the list. The slowest item is an
//   append or a removal at position 63; the link walk sets its time. One item
//   is worked on at a time; busy falls in the cycle after the result.
// Reset:
//   rst_n low (synchronous) empties the list; the free pool is handed out by
//   a fill count, so no clearing pass is needed and start may follow at once.
// Stalls:
//   The receiver cannot hold results off; out_valid lasts one cycle only.
//------------------------------------------------------------------------------
`default_nettype none
module bounded_doubly_linked_list_engine
  import bdll_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            in_command,
  input  wire logic [7:0]            in_position,
  input  wire logic [ValueWidth-1:0] in_value,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [6:0]                 out_found_position,
  output logic [ValueWidth-1:0]      out_read_value,
  output logic [6:0]                 out_length
);
  ctl_t ctl;
  sts_t sts;

  // Sequence the command.
  bdll_ctrl u_ctrl (
    .clk, .rst_n, .start, .cmd(in_command), .sts, .ctl, .busy, .done(out_valid)
  );

  // Hold the pool and build the result.
  bdll_dp u_dp (
    .clk, .rst_n,
    .load(start && !busy),
    .in_cmd(in_command), .in_pos(in_position), .in_val(in_value),
    .ctl, .sts,
    .status(out_status), .found_position(out_found_position),
    .read_value(out_read_value), .length(out_length)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/bdll_checker.sv
//------------------------------------------------------------------------------
// bdll_checker
// Port-level checks of the list engine.
//------------------------------------------------------------------------------
`default_nettype none
`include "bounded_doubly_linked_list_engine_assert.svh"
module bdll_checker
  import bdll_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [1:0] out_status,
  input wire logic [6:0] out_found_position,
  input wire logic [6:0] out_length
);
  `BDL_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy missing after accept")
  `BDL_ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid, busy, "result outside a command")
  `BDL_ASSERT_NEXT(a_one_shot, clk, rst_n, out_valid, !out_valid && !busy, "result repeated")
  `BDL_ASSERT_IMP(a_len_range, clk, rst_n, out_valid, out_length <= 7'(Capacity), "length over pool")
  `BDL_ASSERT_IMP(a_fail_pos, clk, rst_n, out_valid && out_status != StDone, out_found_position == 7'd0, "position on failure")
endmodule
bind bounded_doubly_linked_list_engine bdll_checker u_bdll_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status, .out_found_position, .out_length
);
`default_nettype wire

FILE: tb/sv/tb_bounded_doubly_linked_list_engine.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_bounded_doubly_linked_list_engine
// Self-checking bench for the bounded doubly linked list engine: a directed
// table of commands, then about 1300 random commands in fill, drain and mixed
// phases, checked against typed answers or a queue-based model of the ordered list.
//------------------------------------------------------------------------------
module tb_bounded_doubly_linked_list_engine;
  import bdll_pkg::*;

  // One answer of the engine, as it appears on the out_ ports.
  typedef struct {
    logic [1:0]  status;
    logic [6:0]  found_pos;
    logic [31:0] value;
    logic [6:0]  length;
  } answer_t;

  // One row of the directed table; has_answer marks a typed-in answer.
  typedef struct {
    logic [2:0]  command;
    logic [7:0]  position;
    logic [31:0] value;
    bit          has_answer;
    answer_t     answer;
  } row_t;

  localparam int CycleLimit = 1000000;
  localparam int RandomItems = 1300;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_command;
  logic [7:0]  in_position;
  logic [31:0] in_value;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [6:0]  out_found_position;
  logic [31:0] out_read_value;
  logic [6:0]  out_length;

  logic [31:0] list_values[$];   // model of the ordered list, head first
  answer_t     pending_answers[$];
  row_t        cmd_table[$];
  bit          failed;
  int unsigned cycle_count;
  bit          no_gaps;

  bounded_doubly_linked_list_engine i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_read_value     (out_read_value),
    .out_length         (out_length)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: give up well beyond the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Apply one command to the list model and return the answer it gives.
  function automatic answer_t apply_command(logic [2:0] cmd, logic [7:0] pos,
                                            logic [31:0] val);
    answer_t r;
    int      idx;
    r.status    = StNotFound;
    r.found_pos = '0;
    r.value     = '0;
    case (cmd)
      CmdPushFront, CmdPushBack, CmdInsertAt: begin
        if (list_values.size() >= Capacity) begin
          r.status = StFull;
        end else begin
          if (cmd == CmdPushFront) idx = 0;
          else if (cmd == CmdPushBack) idx = list_values.size();
          else idx = (pos > list_values.size()) ? list_values.size() : pos;
          list_values.insert(idx, val);
          r.status    = StDone;
          r.found_pos = idx[6:0];
          r.value     = val;
        end
      end
      CmdRemoveAt, CmdReadAt: begin
        if (pos < list_values.size()) begin
          r.status    = StDone;
          r.found_pos = pos[6:0];
          r.value     = list_values[pos];
          if (cmd == CmdRemoveAt) list_values.delete(pos);
        end
      end
      CmdRemoveVal, CmdFindVal: begin
        for (idx = 0; idx < list_values.size(); idx++) begin
          if (list_values[idx] == val) begin
            r.status    = StDone;
            r.found_pos = idx[6:0];
            r.value     = val;
            if (cmd == CmdRemoveVal) list_values.delete(idx);
            break;
          end
        end
      end
      default: ;  // unused code: nothing changes
    endcase
    r.length = 7'(list_values.size());
    return r;
  endfunction

  // Hold the item after a random gap until the engine takes it.
  task automatic send_item(logic [2:0] cmd, logic [7:0] pos, logic [31:0] val,
                           bit has_answer, answer_t typed);
    int      gap;
    answer_t predicted;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    in_command  <= cmd;
    in_position <= pos;
    in_value    <= val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predicted = apply_command(cmd, pos, val);
    pending_answers.push_back(has_answer ? typed : predicted);
    // Lower start once the engine has taken the item.
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Compare every answer with the oldest one still awaited.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer status=%0d pos=%0d value=%h len=%0d",
                 $time, out_status, out_found_position, out_read_value, out_length);
        failed = 1'b1;
      end else begin
        want = pending_answers.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
          failed = 1'b1;
        end
        if (out_found_position !== want.found_pos) begin
          $display("%0t: position expected %0d got %0d", $time, want.found_pos,
                   out_found_position);
          failed = 1'b1;
        end
        if (out_read_value !== want.value) begin
          $display("%0t: value expected %h got %h", $time, want.value, out_read_value);
          failed = 1'b1;
        end
        if (out_length !== want.length) begin
          $display("%0t: length expected %0d got %0d", $time, want.length, out_length);
          failed = 1'b1;
        end
      end
    end
  end

  // Add a table row; st below 0 means the answer comes from the model.
  task automatic add_row(logic [2:0] cmd, logic [7:0] pos, logic [31:0] val,
                         int st = -1, int fp = 0, logic [31:0] rv = 0, int ln = 0);
    row_t row;
    row.command          = cmd;
    row.position         = pos;
    row.value            = val;
    row.has_answer       = (st >= 0);
    row.answer.status    = st[1:0];
    row.answer.found_pos = fp[6:0];
    row.answer.value     = rv;
    row.answer.length    = ln[6:0];
    cmd_table.push_back(row);
  endtask

  // Values drawn mostly from a small set so that finds and removes hit.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom_range(0, 11);
    endcase
  endfunction

  initial begin
    int          i;
    int          phase;
    int          weight;
    logic [2:0]  cmd;
    logic [7:0]  pos;
    answer_t     none;
    none          = '{default: '0};
    failed        = 1'b0;
    cycle_count   = 0;
    no_gaps       = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CmdPushFront;
    in_position   = '0;
    in_value      = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, extremes, every command, head/tail/only removal.
    add_row(CmdReadAt,    8'd0,   32'h0, StNotFound, 0, 0, 0);
    add_row(CmdRemoveAt,  8'd0,   32'h0, StNotFound, 0, 0, 0);
    add_row(CmdFindVal,   8'd0,   32'h0, StNotFound, 0, 0, 0);
    add_row(CmdRemoveVal, 8'd0,   32'h0, StNotFound, 0, 0, 0);
    add_row(CmdPushFront, 8'd0,   32'hFFFF_FFFF, StDone, 0, 32'hFFFF_FFFF, 1);
    add_row(CmdRemoveAt,  8'd0,   32'h0, StDone, 0, 32'hFFFF_FFFF, 0);
    add_row(CmdPushBack,  8'hFF,  32'h0, StDone, 0, 32'h0, 1);
    add_row(CmdInsertAt,  8'hFF,  32'h5555_AAAA, StDone, 1, 32'h5555_AAAA, 2);
    add_row(CmdInsertAt,  8'd0,   32'hAAAA_5555);
    add_row(CmdInsertAt,  8'd1,   32'h1234_5678);
    add_row(CmdReadAt,    8'hFF,  32'h0, StNotFound, 0, 0, 4);
    add_row(CmdUnused,    8'd0,   32'h0, StNotFound, 0, 0, 4);
    add_row(CmdReadAt,    8'd3,   32'h0);
    add_row(CmdFindVal,   8'd0,   32'h1234_5678);
    add_row(CmdFindVal,   8'd0,   32'hDEAD_BEEF);
    add_row(CmdRemoveVal, 8'd0,   32'h5555_AAAA);
    add_row(CmdRemoveAt,  8'd0,   32'h0);
    add_row(CmdRemoveAt,  8'd1,   32'h0);
    add_row(CmdRemoveVal, 8'd0,   32'h1234_5678);
    add_row(CmdRemoveVal, 8'd0,   32'h1234_5678, StNotFound, 0, 0, 0);
    foreach (cmd_table[k])
      send_item(cmd_table[k].command, cmd_table[k].position, cmd_table[k].value,
                cmd_table[k].has_answer, cmd_table[k].answer);

    // Random: phases of 100 items that fill, drain or churn the list.
    for (i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) begin
        phase   = $urandom_range(0, 2);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if (i == RandomItems / 2) begin
        // Pause until the engine has answered everything sent so far.
        while (pending_answers.size() != 0) @(negedge clk);
      end
      weight = $urandom_range(0, 99);
      case (phase)
        0:       cmd = (weight < 75) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(3, 7));
        1:       cmd = (weight < 70) ? 3'($urandom_range(3, 4)) : 3'($urandom_range(0, 7));
        default: cmd = 3'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 4) == 0) pos = 8'($urandom_range(0, 255));
      else pos = 8'($urandom_range(0, list_values.size() + 1));
      send_item(cmd, pos, pick_value(), 1'b0, none);
    end

    while (pending_answers.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
